@@ rtl/ouvl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types and codes for the ordered unique value list.
// No dependencies; every other file imports this package.

package ouvl_pkg;

   // Fixed field widths of the request and response transfers
   localparam int OP_W     = 2;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;
   localparam int POS_W    = 5;

   // Operation codes
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

   // Response status codes
   localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_REMOVED   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd4;
   localparam logic [STATUS_W-1:0] STAT_EMPTY     = 3'd5;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd6;

   // Control of the probe that walks down the cell row
   typedef struct packed {
      logic active;
      logic hit;
   } probe_ctl_type;

   // Update command broadcast to every cell
   typedef struct packed {
      logic load;    // write the value into the target cell
      logic shift;   // cells at or past the target take their right neighbor
   } cell_cmd_type;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } ctrl_state_type;

endpackage

`default_nettype wire

@@ rtl/ouvl_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel interfaces for requests and responses.
// Depends on ouvl_pkg for the field widths.

interface ouvl_req_if import ouvl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface ouvl_rsp_if import ouvl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [POS_W-1:0]    position;

   modport source (output valid, output status, output position, input ready);
   modport sink   (input valid, input status, input position, output ready);
endinterface

`default_nettype wire

@@ rtl/ouvl_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One storage cell of the list: holds one entry and one stage of the probe.
// Depends on ouvl_pkg for the probe and command types.

module ouvl_cell import ouvl_pkg::*; #(
   parameter int DEPTH = 16,
   parameter int IDX   = 0
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [$clog2(DEPTH+1)-1:0]        count,
   input  wire cell_cmd_type                      cmd,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] cmd_target,
   input  wire logic [VALUE_W-1:0]                cmd_value,
   input  wire logic [VALUE_W-1:0]                right_entry,
   output logic      [VALUE_W-1:0]                entry,
   input  wire probe_ctl_type                     probe_ctl_in,
   input  wire logic [VALUE_W-1:0]                probe_key_in,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] probe_idx_in,
   output probe_ctl_type                          probe_ctl_out,
   output logic      [VALUE_W-1:0]                probe_key_out,
   output logic      [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] probe_idx_out
);

   localparam int CNT_W = $clog2(DEPTH+1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);
   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

   logic [VALUE_W-1:0] entry_ff, entry_in;
   probe_ctl_type      ctl_ff, ctl_in;
   logic [VALUE_W-1:0] key_ff;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               occupied;

   assign occupied = (MY_CNT < count);

   // Load on insert, take the right neighbor on remove, otherwise hold
   always_comb begin
      entry_in = entry_ff;
      if (cmd.load && (cmd_target == MY_IDX)) begin
         entry_in = cmd_value;
      end else if (cmd.shift && (MY_IDX >= cmd_target)) begin
         entry_in = right_entry;
      end
   end

   // Compare the passing probe; keep the first hit
   always_comb begin
      ctl_in = probe_ctl_in;
      idx_in = probe_idx_in;
      if (probe_ctl_in.active && !probe_ctl_in.hit && occupied &&
          (entry_ff == probe_key_in)) begin
         ctl_in.hit = 1'b1;
         idx_in     = MY_IDX;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      key_ff   <= probe_key_in;
      idx_ff   <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   assign entry         = entry_ff;
   assign probe_ctl_out = ctl_ff;
   assign probe_key_out = key_ff;
   assign probe_idx_out = idx_ff;

endmodule

`default_nettype wire

@@ rtl/ordered_unique_value_list.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Top level of the ordered unique value list: controller and the cell row.
// Depends on ouvl_pkg, ouvl_if and ouvl_cell.
//
//   channel   direction  fields              transfer when
//   req_bus   in         op, value           valid && ready
//   rsp_bus   out        status, position    valid && ready
//
// Each request sends a probe down the row of DEPTH cells, one cell a cycle;
// the probe's walk sets the latency of each request.
// Inserts and removals are applied to all cells in the same cycle once the probe
// leaves the row. Synchronous reset empties the list at once.
// A new request is taken while an earlier response still waits; a stalled
// response holds the controller before it loads the next one.

module ordered_unique_value_list import ouvl_pkg::*; #(
   parameter int DEPTH = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ouvl_req_if.sink   req_bus,
   ouvl_rsp_if.source rsp_bus
);

   localparam int CNT_W = $clog2(DEPTH+1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ctrl_state_type       state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [OP_W-1:0]      op_ff;
   logic [VALUE_W-1:0]   key_ff;
   logic                 launch_ff, launch_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [POS_W-1:0]     res_pos_ff, res_pos_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [POS_W-1:0]     rsp_pos_ff;
   logic                 rsp_load;
   logic                 req_xfer;

   cell_cmd_type         cmd;
   logic [IDX_W-1:0]     cmd_target;
   logic [IDX_W:0]       found_pos;

   probe_ctl_type        probe_ctl [DEPTH+1];
   logic [VALUE_W-1:0]   probe_key [DEPTH+1];
   logic [IDX_W-1:0]     probe_idx [DEPTH+1];
   logic [VALUE_W-1:0]   entry_w   [DEPTH+1];

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_xfer      = req_bus.valid && req_bus.ready;

   // Inject the probe at the head of the row
   assign probe_ctl[0].active = launch_ff;
   assign probe_ctl[0].hit    = 1'b0;
   assign probe_key[0]        = key_ff;
   assign probe_idx[0]        = '0;
   assign entry_w[DEPTH]      = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      ouvl_cell #(
         .DEPTH (DEPTH),
         .IDX   (i)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .count         (count_ff),
         .cmd           (cmd),
         .cmd_target    (cmd_target),
         .cmd_value     (key_ff),
         .right_entry   (entry_w[i+1]),
         .entry         (entry_w[i]),
         .probe_ctl_in  (probe_ctl[i]),
         .probe_key_in  (probe_key[i]),
         .probe_idx_in  (probe_idx[i]),
         .probe_ctl_out (probe_ctl[i+1]),
         .probe_key_out (probe_key[i+1]),
         .probe_idx_out (probe_idx[i+1])
      );
   end

   assign found_pos = {1'b0, probe_idx[DEPTH]} + 1'b1;

   // Sequence each request and decide its outcome when the probe drains
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      launch_in     = 1'b0;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      cmd           = '0;
      cmd_target    = probe_idx[DEPTH];
      rsp_load      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               launch_in = 1'b1;
               state_in  = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (probe_ctl[DEPTH].active) begin
               state_in      = ST_DONE;
               res_status_in = STAT_NOT_FOUND;
               res_pos_in    = '0;
               unique case (op_ff)
                  OP_INSERT: begin
                     if (count_ff == FULL_CNT) begin
                        res_status_in = STAT_FULL;
                     end else if (probe_ctl[DEPTH].hit) begin
                        res_status_in = STAT_DUPLICATE;
                     end else begin
                        res_status_in = STAT_INSERTED;
                        cmd.load      = 1'b1;
                        cmd_target    = IDX_W'(count_ff);
                        count_in      = count_ff + 1'b1;
                     end
                  end
                  OP_REMOVE: begin
                     if (count_ff == '0) begin
                        res_status_in = STAT_EMPTY;
                     end else if (probe_ctl[DEPTH].hit) begin
                        res_status_in = STAT_REMOVED;
                        cmd.shift     = 1'b1;
                        count_in      = count_ff - 1'b1;
                     end
                  end
                  OP_SEARCH: begin
                     if (probe_ctl[DEPTH].hit) begin
                        res_status_in = STAT_FOUND;
                        res_pos_in    = POS_W'(found_pos);
                     end
                  end
                  default: begin
                     res_status_in = STAT_NOT_FOUND;
                  end
               endcase
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the response until the sink takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture request and result payloads
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff  <= req_bus.op;
         key_ff <= req_bus.value;
      end
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_pos_ff    <= res_pos_ff;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.status   = rsp_status_ff;
   assign rsp_bus.position = rsp_pos_ff;

endmodule

`default_nettype wire

@@ verif/ordered_unique_value_list_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the ordered unique value list: directed and random
// insert/remove/search traffic with random stalls on both channels.
// Depends on ouvl_pkg, ouvl_if and the ordered_unique_value_list RTL.

module ordered_unique_value_list_test;
   import ouvl_pkg::*;

   localparam int LIST_DEPTH     = 16;
   localparam int POOL_SIZE      = 28;
   localparam int RANDOM_ITEMS   = 1280;
   localparam int LONG_STALL     = 300;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int TAIL_CYCLES    = 2 * LIST_DEPTH + 8;

   // Op code with no operation behind it
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   // Kinds of random phases
   localparam int PHASE_FILL  = 0;
   localparam int PHASE_DRAIN = 1;
   localparam int PHASE_MIXED = 2;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [VALUE_W-1:0] value;
      int unsigned        gap;
      bit                 drain_first;
   } list_request_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
   } list_reply_type;

   logic clock;
   logic reset;

   ouvl_req_if req_ch ();
   ouvl_rsp_if rsp_ch ();

   ordered_unique_value_list #(
      .DEPTH(LIST_DEPTH)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch)
   );

   list_request_type   pending_requests[$];
   list_reply_type     expected_replies[$];
   logic [VALUE_W-1:0] list_values[$];
   logic [VALUE_W-1:0] value_pool[POOL_SIZE];

   int unsigned items_accepted;
   int unsigned results_seen;
   int unsigned gap_count;
   int unsigned stall_left;
   int unsigned calm_left;
   int unsigned long_stalls_done;
   int unsigned quiet_cycles;
   int          error_count;
   logic        sender_idle;

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 60);
   endfunction

   // Apply one operation to the mirrored list and return the reply it earns
   function automatic list_reply_type predict_list_op(input logic [OP_W-1:0] op,
                                                      input logic [VALUE_W-1:0] value);
      list_reply_type reply;
      int             hit;
      hit = -1;
      foreach (list_values[i]) begin
         if (hit < 0 && list_values[i] == value) hit = i;
      end
      reply.status   = STAT_NOT_FOUND;
      reply.position = '0;
      case (op)
         OP_INSERT: begin
            // a full store wins over a duplicate
            if (list_values.size() >= LIST_DEPTH) begin
               reply.status = STAT_FULL;
            end else if (hit >= 0) begin
               reply.status = STAT_DUPLICATE;
            end else begin
               list_values.push_back(value);
               reply.status = STAT_INSERTED;
            end
         end
         OP_REMOVE: begin
            if (list_values.size() == 0) begin
               reply.status = STAT_EMPTY;
            end else if (hit >= 0) begin
               list_values.delete(hit);
               reply.status = STAT_REMOVED;
            end
         end
         OP_SEARCH: begin
            // an empty list simply has no match
            if (hit >= 0) begin
               reply.status   = STAT_FOUND;
               reply.position = POS_W'(hit + 1);
            end
         end
         default: ;
      endcase
      return reply;
   endfunction

   task automatic add_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                              input int unsigned gap, input bit drain_first);
      list_request_type item;
      item.op          = op;
      item.value       = value;
      item.gap         = gap;
      item.drain_first = drain_first;
      pending_requests.push_back(item);
   endtask

   // Random value, sometimes replaced by an extreme
   function automatic logic [VALUE_W-1:0] pick_pool_value();
      case ($urandom_range(0, 15))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Sender: hold the current request until transfer, then load the next one
   always @(posedge clock) begin
      logic             take;
      logic             offer;
      int unsigned      owed;
      list_request_type next_item;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.op    <= OP_INSERT;
         req_ch.value <= '0;
         sender_idle  <= 1'b0;
         gap_count    = 0;
      end else begin
         take = req_ch.valid && req_ch.ready;
         if (take) begin
            expected_replies.push_back(predict_list_op(req_ch.op, req_ch.value));
            items_accepted <= items_accepted + 1;
         end
         offer = req_ch.valid && !take;
         if (!offer && pending_requests.size() != 0) begin
            owed = items_accepted + (take ? 1 : 0);
            if (pending_requests[0].drain_first && owed != results_seen) begin
               // hold off until every reply is back
            end else if (gap_count < pending_requests[0].gap) begin
               gap_count++;
            end else begin
               next_item    = pending_requests.pop_front();
               gap_count    = 0;
               offer        = 1'b1;
               req_ch.op    <= next_item.op;
               req_ch.value <= next_item.value;
            end
         end
         req_ch.valid <= offer;
         sender_idle  <= !offer && pending_requests.size() == 0;
      end
   end

   // Receiver: check each reply transfer and throttle ready
   always @(posedge clock) begin
      list_reply_type want;
      logic           ready_next;
      int unsigned    g;
      if (reset) begin
         rsp_ch.ready     <= 1'b0;
         results_seen     <= 0;
         stall_left       = 0;
         calm_left        = 0;
         long_stalls_done = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            results_seen <= results_seen + 1;
            if (expected_replies.size() == 0) begin
               $error("reply with nothing outstanding: status %0d position %0d",
                      rsp_ch.status, rsp_ch.position);
               error_count++;
            end else begin
               want = expected_replies.pop_front();
               if (rsp_ch.status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_ch.status);
                  error_count++;
               end
               if (rsp_ch.position !== want.position) begin
                  $error("position mismatch: expected %0d, actual %0d",
                         want.position, rsp_ch.position);
                  error_count++;
               end
            end
         end

         // long hold-off while the sender keeps offering, so the block backs up
         if (stall_left > 0) begin
            stall_left--;
            ready_next = 1'b0;
         end else if (long_stalls_done < 2 && req_ch.valid &&
                      results_seen >= (long_stalls_done + 1) * 400) begin
            stall_left = LONG_STALL - 1;
            long_stalls_done++;
            ready_next = 1'b0;
         end else if (calm_left > 0) begin
            calm_left--;
            ready_next = 1'b1;
         end else begin
            if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(20, 80);
            g = ($urandom_range(0, 9) < 4) ? pick_gap() : 0;
            if (g > 0) begin
               stall_left = g - 1;
               ready_next = 1'b0;
            end else begin
               ready_next = 1'b1;
            end
         end
         rsp_ch.ready <= ready_next;
      end
   end

   // Watchdog: end the run when no transfer happens for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned total;
      int unsigned phase_index;
      int unsigned phase_len;
      int unsigned phase_kind;
      int unsigned pool_n;
      int unsigned insert_pct;
      int unsigned remove_pct;
      int unsigned r;
      bit          steady;
      logic [OP_W-1:0]    op;
      logic [VALUE_W-1:0] value;

      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.op      = OP_INSERT;
      req_ch.value   = '0;
      rsp_ch.ready   = 1'b0;
      items_accepted = 0;
      results_seen   = 0;
      quiet_cycles   = 0;
      error_count    = 0;
      sender_idle    = 1'b0;

      // Directed: empty-list cases, extremes, duplicates, order kept on removal
      add_request(OP_SEARCH, 32'h0000_0005, 0, 0);
      add_request(OP_REMOVE, 32'h0000_0005, 0, 0);
      add_request(OP_UNUSED, 32'h0000_0007, 0, 0);
      add_request(OP_INSERT, 32'h8000_0000, 0, 0);
      add_request(OP_INSERT, 32'h7FFF_FFFF, 0, 0);
      add_request(OP_INSERT, 32'h0000_0000, 1, 0);
      add_request(OP_INSERT, 32'hFFFF_FFFF, 0, 0);
      add_request(OP_INSERT, 32'h7FFF_FFFF, 0, 0);
      add_request(OP_SEARCH, 32'hFFFF_FFFF, 0, 0);
      add_request(OP_SEARCH, 32'h8000_0000, 2, 0);
      add_request(OP_REMOVE, 32'h7FFF_FFFF, 0, 0);
      add_request(OP_SEARCH, 32'hFFFF_FFFF, 0, 0);
      add_request(OP_REMOVE, 32'h1234_5678, 0, 0);
      add_request(OP_UNUSED, 32'h8000_0000, 0, 0);
      add_request(OP_REMOVE, 32'h8000_0000, 0, 0);
      add_request(OP_SEARCH, 32'h0000_0000, 0, 0);

      // Random: phases that fill, drain or mix over a slowly changing value pool
      foreach (value_pool[k]) value_pool[k] = pick_pool_value();
      total       = 0;
      phase_index = 0;
      while (total < RANDOM_ITEMS) begin
         phase_len  = $urandom_range(30, 90);
         phase_kind = $urandom_range(PHASE_FILL, PHASE_MIXED);
         steady     = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(0, 6)) value_pool[$urandom_range(0, POOL_SIZE - 1)] =
            pick_pool_value();
         case (phase_kind)
            PHASE_FILL:  begin insert_pct = 65; remove_pct = 15; pool_n = POOL_SIZE; end
            PHASE_DRAIN: begin insert_pct = 20; remove_pct = 60; pool_n = POOL_SIZE; end
            default: begin
               insert_pct = 35;
               remove_pct = 30;
               pool_n     = $urandom_range(4, POOL_SIZE);
            end
         endcase
         for (int n = 0; n < phase_len; n++) begin
            r = $urandom_range(0, 99);
            if (r < 3) op = OP_UNUSED;
            else if (r < 3 + insert_pct) op = OP_INSERT;
            else if (r < 3 + insert_pct + remove_pct) op = OP_REMOVE;
            else op = OP_SEARCH;
            // mostly pool values, a few fresh ones that are almost surely absent
            if ($urandom_range(0, 11) == 0) value = $urandom;
            else value = value_pool[$urandom_range(0, pool_n - 1)];
            add_request(op, value, steady ? 0 : pick_gap(), n == 0 && phase_index % 6 == 0);
         end
         total += phase_len;
         phase_index++;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Wait for the last request to go out and every reply to come back
      do @(posedge clock);
      while (!sender_idle || results_seen != items_accepted);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_replies.size() != 0) begin
         $error("%0d replies never arrived", expected_replies.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
